FILE: sv/pbvs_pkg.sv
// pbvs_pkg: shared constants, action codes, memory request type and capacity table
// for the partitioned byte vector store; no dependencies
package pbvs_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int MAX_VECTORS = 16;

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CAP_W  = $clog2(STORE_DEPTH + 1);
	localparam int ID_W   = 4;
	localparam int IDX_W  = 12;
	localparam int BYTE_W = 8;
	localparam int ACT_W  = 3;
	localparam int VCNT_W = 5;
	localparam int FILL_W = 13;
	localparam int OFF_W  = (IDX_W > CAP_W) ? IDX_W : CAP_W;
	localparam int PROD_W = ID_W + CAP_W;

	typedef logic [ACT_W-1:0] action_t;

	localparam action_t ACT_PUSH      = 3'd0;
	localparam action_t ACT_READ      = 3'd1;
	localparam action_t ACT_WRITE     = 3'd2;
	localparam action_t ACT_CLEAR_ONE = 3'd3;
	localparam action_t ACT_CLEAR_ALL = 3'd4;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} mem_req_t;

	// segment capacity for a vector count, zero when disabled
	function automatic logic [CAP_W-1:0] cap_of(logic [VCNT_W-1:0] n);
		logic [CAP_W-1:0] c;
		c = '0;
		case (n)
			5'd1:  c = CAP_W'(STORE_DEPTH / 1);
			5'd2:  c = CAP_W'(STORE_DEPTH / 2);
			5'd3:  c = CAP_W'(STORE_DEPTH / 3);
			5'd4:  c = CAP_W'(STORE_DEPTH / 4);
			5'd5:  c = CAP_W'(STORE_DEPTH / 5);
			5'd6:  c = CAP_W'(STORE_DEPTH / 6);
			5'd7:  c = CAP_W'(STORE_DEPTH / 7);
			5'd8:  c = CAP_W'(STORE_DEPTH / 8);
			5'd9:  c = CAP_W'(STORE_DEPTH / 9);
			5'd10: c = CAP_W'(STORE_DEPTH / 10);
			5'd11: c = CAP_W'(STORE_DEPTH / 11);
			5'd12: c = CAP_W'(STORE_DEPTH / 12);
			5'd13: c = CAP_W'(STORE_DEPTH / 13);
			5'd14: c = CAP_W'(STORE_DEPTH / 14);
			5'd15: c = CAP_W'(STORE_DEPTH / 15);
			5'd16: c = CAP_W'(STORE_DEPTH / 16);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/pbvs_if.sv
// pbvs channel interfaces: request, response and configuration write
// depends on pbvs_pkg
interface pbvs_req_if;
	logic                          valid;
	logic                          ready;
	logic [pbvs_pkg::ACT_W-1:0]    action;
	logic [pbvs_pkg::ID_W-1:0]     vector_id;
	logic [pbvs_pkg::IDX_W-1:0]    index;
	logic [pbvs_pkg::BYTE_W-1:0]   value;

	modport source (output valid, action, vector_id, index, value, input ready);
	modport sink (input valid, action, vector_id, index, value, output ready);
endinterface

interface pbvs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [pbvs_pkg::BYTE_W-1:0]   read_data;
	logic [pbvs_pkg::FILL_W-1:0]   fill_count;
	logic [pbvs_pkg::FILL_W-1:0]   segment_capacity;

	modport source (output valid, accepted, read_data, fill_count, segment_capacity,
		input ready);
	modport sink (input valid, accepted, read_data, fill_count, segment_capacity,
		output ready);
endinterface

interface pbvs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pbvs_pkg::VCNT_W-1:0]   vector_count;

	modport source (output valid, vector_count, input ready);
	modport sink (input valid, vector_count, output ready);
endinterface

FILE: sv/pbvs_byte_ram.sv
// pbvs_byte_ram: single-port byte store with registered read data
// depends on pbvs_pkg
module pbvs_byte_ram (
	input  logic                          clk,
	input  pbvs_pkg::mem_req_t            mem_req,
	output logic [pbvs_pkg::BYTE_W-1:0]   rdata
);

	logic [pbvs_pkg::BYTE_W-1:0] mem [pbvs_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.addr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rdata <= mem[mem_req.addr];
		end
	end

endmodule

FILE: sv/pbvs_ctrl.sv
// pbvs_ctrl: configuration, fill counts, action decode, result stage and clear sweep
// depends on pbvs_pkg, pbvs_if
module pbvs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	pbvs_req_if.sink                      req,
	pbvs_rsp_if.source                    rsp,
	pbvs_cfg_if.sink                      cfg,
	output pbvs_pkg::mem_req_t            mem_req,
	input  logic [pbvs_pkg::BYTE_W-1:0]   mem_rdata
);

	logic [pbvs_pkg::VCNT_W-1:0] vcount_q;
	logic                        active_q;
	logic [pbvs_pkg::CAP_W-1:0]  cap_q;
	logic [pbvs_pkg::CAP_W-1:0]  counts_q [pbvs_pkg::MAX_VECTORS];

	logic                        clearing_q;
	logic [pbvs_pkg::ADDR_W-1:0] clr_addr_q;

	logic                        valid_s1;
	logic                        accepted_s1;
	logic                        rd_sel_s1;
	logic [pbvs_pkg::FILL_W-1:0] fill_s1;
	logic [pbvs_pkg::FILL_W-1:0] cap_s1;

	logic                        accept;
	logic                        ok;
	logic                        acc;
	logic                        do_we;
	logic                        do_re;
	logic                        cnt_we;
	logic                        clr_all;
	logic                        use_fill;
	logic [pbvs_pkg::CAP_W-1:0]  cur;
	logic [pbvs_pkg::CAP_W-1:0]  nxt;
	logic [pbvs_pkg::OFF_W-1:0]  idx_ext;
	logic [pbvs_pkg::OFF_W-1:0]  cap_ext;
	logic [pbvs_pkg::OFF_W-1:0]  cur_ext;
	logic                        idx_in;
	logic [pbvs_pkg::PROD_W-1:0] offs;
	logic [pbvs_pkg::PROD_W-1:0] addr_full;

	assign cfg.ready = 1'b1;
	assign req.ready = !clearing_q && (!valid_s1 || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign ok      = active_q && ({1'b0, req.vector_id} < vcount_q);
	assign cur     = counts_q[req.vector_id];
	assign idx_ext = pbvs_pkg::OFF_W'(req.index);
	assign cap_ext = pbvs_pkg::OFF_W'(cap_q);
	assign cur_ext = pbvs_pkg::OFF_W'(cur);
	assign idx_in  = idx_ext < cap_ext;

	always_comb begin
		acc      = 1'b0;
		do_we    = 1'b0;
		do_re    = 1'b0;
		cnt_we   = 1'b0;
		clr_all  = 1'b0;
		use_fill = 1'b0;
		nxt      = cur;
		case (req.action)
			pbvs_pkg::ACT_PUSH: begin
				use_fill = 1'b1;
				if (ok && (cur < cap_q)) begin
					acc    = 1'b1;
					do_we  = 1'b1;
					cnt_we = 1'b1;
					nxt    = cur + 1'b1;
				end
			end
			pbvs_pkg::ACT_READ: begin
				if (ok && idx_in) begin
					acc   = 1'b1;
					do_re = 1'b1;
				end
			end
			pbvs_pkg::ACT_WRITE: begin
				if (ok && idx_in) begin
					acc    = 1'b1;
					do_we  = 1'b1;
					cnt_we = 1'b1;
					if (idx_ext >= cur_ext) begin
						nxt = pbvs_pkg::CAP_W'(idx_ext + 1'b1);
					end
				end
			end
			pbvs_pkg::ACT_CLEAR_ONE: begin
				if (ok) begin
					acc    = 1'b1;
					cnt_we = 1'b1;
					nxt    = '0;
				end
			end
			pbvs_pkg::ACT_CLEAR_ALL: begin
				acc     = ok;
				clr_all = 1'b1;
				nxt     = '0;
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	// segment base plus element offset
	assign offs      = use_fill ? pbvs_pkg::PROD_W'(cur) : pbvs_pkg::PROD_W'(req.index);
	assign addr_full = pbvs_pkg::PROD_W'(req.vector_id) * pbvs_pkg::PROD_W'(cap_q) + offs;

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = addr_full[pbvs_pkg::ADDR_W-1:0];
		mem_req.wdata = req.value;
		if (clearing_q) begin
			mem_req.we    = 1'b1;
			mem_req.addr  = clr_addr_q;
			mem_req.wdata = '0;
		end else if (accept) begin
			mem_req.we = do_we;
			mem_req.re = do_re;
		end
	end

	// zero sweep of the byte store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == pbvs_pkg::ADDR_W'(pbvs_pkg::STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			active_q <= 1'b0;
			cap_q    <= '0;
		end else if (cfg.valid && cfg.ready) begin
			vcount_q <= cfg.vector_count;
			cap_q    <= pbvs_pkg::cap_of(cfg.vector_count);
			active_q <= (cfg.vector_count != '0) &&
				({1'b0, cfg.vector_count} <= (pbvs_pkg::VCNT_W + 1)'(pbvs_pkg::MAX_VECTORS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pbvs_pkg::MAX_VECTORS; k++) begin
				counts_q[k] <= '0;
			end
		end else if ((cfg.valid && cfg.ready) || (accept && clr_all)) begin
			for (int k = 0; k < pbvs_pkg::MAX_VECTORS; k++) begin
				counts_q[k] <= '0;
			end
		end else if (accept && cnt_we) begin
			counts_q[req.vector_id] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			accepted_s1 <= acc;
			rd_sel_s1   <= do_re;
			fill_s1     <= ok ? pbvs_pkg::FILL_W'(nxt) : '0;
			cap_s1      <= ok ? pbvs_pkg::FILL_W'(cap_q) : '0;
		end
	end

	assign rsp.valid            = valid_s1;
	assign rsp.accepted         = accepted_s1;
	assign rsp.read_data        = rd_sel_s1 ? mem_rdata : '0;
	assign rsp.fill_count       = fill_s1;
	assign rsp.segment_capacity = cap_s1;

`ifndef ASSERT_OFF
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.ready)
		else $error("item accepted during store sweep");

	a_read_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> (accept && ok && !clearing_q))
		else $error("store read without an accepted beat");

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && !clearing_q) |-> (accept && ok))
		else $error("store write without an accepted beat");

	a_fill_in_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && accepted_s1) |-> (fill_s1 <= cap_s1))
		else $error("fill count above segment capacity");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !rsp.ready) |=> (valid_s1 && $stable(fill_s1) && $stable(rd_sel_s1)))
		else $error("result stage changed while stalled");
`endif

endmodule

FILE: sv/partitioned_byte_vector_store.sv
// partitioned_byte_vector_store: top level, ties the control stage to the byte store
// depends on pbvs_pkg, pbvs_if, pbvs_byte_ram, pbvs_ctrl
//
// usage
//   cfg: one beat writes vector_count (1..16 segments, 0 or above 16 disables);
//   it clears every fill count and leaves the stored bytes as they are.
//   write it only while no request is in flight.
//   req: one beat is one action (push, read, write at index, clear one,
//   clear all) on vector_id; rsp: exactly one beat per request, in order.
//   the response is valid in the cycle after the request beat.
//   throughput: one request per cycle unless a stall or the sweep holds req.ready
//   low; the single store port takes any read or write of each request, and fill
//   counts update in the same cycle. reset: counts and configuration clear at once;
//   the byte store is then zeroed one entry per cycle over all 4096 entries, during
//   which req.ready is low (cfg beats are still taken).
//   stall: while rsp.ready is low the response holds and req.ready drops,
//   so no request is lost or reordered.
module partitioned_byte_vector_store (
	input  logic        clk,
	input  logic        arst_n,
	pbvs_req_if.sink    req,
	pbvs_rsp_if.source  rsp,
	pbvs_cfg_if.sink    cfg
);

	pbvs_pkg::mem_req_t          mem_req;
	logic [pbvs_pkg::BYTE_W-1:0] mem_rdata;

	pbvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	pbvs_byte_ram u_ram (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

endmodule

FILE: sim/pbvs_store_checker.sv
`timescale 1ns / 100ps
// pbvs_store_checker: watches the cfg, req and rsp channels of the partitioned byte vector
// store, keeps a shadow copy of the segments and fill counts, and checks every response beat
// depends on pbvs_pkg and the pbvs channel interfaces
module pbvs_store_checker (
	input  logic clk,
	input  logic arst_n,
	pbvs_req_if  req,
	pbvs_rsp_if  rsp,
	pbvs_cfg_if  cfg,
	output int   mismatches,
	output int   pending,
	output int   checked
);
	import pbvs_pkg::*;

	typedef struct packed {
		logic              accepted;
		logic [BYTE_W-1:0] read_data;
		logic [FILL_W-1:0] fill_count;
		logic [FILL_W-1:0] segment_capacity;
	} outcome_t;

	logic [BYTE_W-1:0] shadow_bytes [STORE_DEPTH];
	int unsigned       shadow_fill [MAX_VECTORS];
	int unsigned       seg_cap = 0;
	int unsigned       live_vectors = 0;
	outcome_t          outcome_q[$];
	int                bad_beats = 0;
	int                good_beats = 0;

	function automatic void load_vector_count(logic [VCNT_W-1:0] n);
		foreach (shadow_fill[k]) shadow_fill[k] = 0;
		if (n == 0 || n > MAX_VECTORS) begin
			seg_cap = 0;
			live_vectors = 0;
		end else begin
			seg_cap = STORE_DEPTH / n;
			live_vectors = (seg_cap == 0) ? 0 : n;
		end
	endfunction

	function automatic outcome_t apply_action(action_t act, logic [ID_W-1:0] vid,
			logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
		outcome_t    o;
		bit          hit;
		int unsigned base;
		o = '0;
		hit = live_vectors != 0 && seg_cap != 0 && vid < live_vectors;
		base = vid * seg_cap;
		case (act)
			ACT_PUSH: begin
				if (hit && shadow_fill[vid] < seg_cap && base + shadow_fill[vid] < STORE_DEPTH) begin
					shadow_bytes[base + shadow_fill[vid]] = val;
					shadow_fill[vid]++;
					o.accepted = 1'b1;
				end
			end
			ACT_READ: begin
				if (hit && idx < seg_cap && base + idx < STORE_DEPTH) begin
					o.read_data = shadow_bytes[base + idx];
					o.accepted = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (hit && idx < seg_cap && base + idx < STORE_DEPTH) begin
					shadow_bytes[base + idx] = val;
					if (idx >= shadow_fill[vid])
						shadow_fill[vid] = idx + 1;
					o.accepted = 1'b1;
				end
			end
			ACT_CLEAR_ONE: begin
				if (hit) begin
					shadow_fill[vid] = 0;
					o.accepted = 1'b1;
				end
			end
			ACT_CLEAR_ALL: begin
				foreach (shadow_fill[k]) shadow_fill[k] = 0;
				o.accepted = hit;
			end
			default: begin
			end
		endcase
		if (hit) begin
			o.fill_count = FILL_W'(shadow_fill[vid]);
			o.segment_capacity = FILL_W'(seg_cap);
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			foreach (shadow_bytes[a]) shadow_bytes[a] = '0;
			foreach (shadow_fill[k]) shadow_fill[k] = 0;
			seg_cap = 0;
			live_vectors = 0;
			outcome_q.delete();
			bad_beats = 0;
			good_beats = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.accepted = rsp.accepted;
				got.read_data = rsp.read_data;
				got.fill_count = rsp.fill_count;
				got.segment_capacity = rsp.segment_capacity;
				if (outcome_q.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("%0t: rsp beat with nothing outstanding: acc %0b data %02h fill %0d cap %0d",
							$time, got.accepted, got.read_data, got.fill_count,
							got.segment_capacity);
				end else begin
					want = outcome_q.pop_front();
					good_beats++;
					if (got !== want) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display({"%0t: rsp mismatch (exp/got) acc %0b/%0b data %02h/%02h ",
								"fill %0d/%0d cap %0d/%0d"}, $time,
								want.accepted, got.accepted, want.read_data, got.read_data,
								want.fill_count, got.fill_count,
								want.segment_capacity, got.segment_capacity);
					end
				end
			end
			if (cfg.valid && cfg.ready)
				load_vector_count(cfg.vector_count);
			if (req.valid && req.ready)
				outcome_q.push_back(apply_action(req.action, req.vector_id, req.index, req.value));
		end
		mismatches <= bad_beats;
		checked <= good_beats;
		pending <= outcome_q.size();
	end

endmodule

FILE: sim/partitioned_byte_vector_store_tb.sv
`timescale 1ns / 100ps
// partitioned_byte_vector_store_tb: drives directed and random actions and vector count
// settings into the store with random idling, and gives the verdict from the checker
// depends on pbvs_pkg, the pbvs channel interfaces, pbvs_store_checker and the block
module partitioned_byte_vector_store_tb;
	import pbvs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 11;

	logic clk;
	logic arst_n;

	pbvs_req_if req_ch();
	pbvs_rsp_if rsp_ch();
	pbvs_cfg_if cfg_ch();

	int                mismatches;
	int                pending;
	int                checked;
	int                cycles = 0;
	int                requests = 0;
	int                settings = 0;
	bit                quiet = 1'b0;
	bit                want_hold = 1'b0;
	bit                hold_done = 1'b0;
	logic [VCNT_W-1:0] cur_count = '0;
	logic [VCNT_W-1:0] phase_counts [PHASES];

	partitioned_byte_vector_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	pbvs_store_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// response side: random stalls, one long hold-off to back up the request path
	initial begin
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (want_hold && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			gap = quiet ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	task automatic send_beat(action_t act, logic [ID_W-1:0] vid, logic [IDX_W-1:0] idx,
			logic [BYTE_W-1:0] val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.vector_id <= vid;
		req_ch.index <= idx;
		req_ch.value <= val;
		do @(posedge clk); while (!req_ch.ready);
		requests++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_vector_count(logic [VCNT_W-1:0] n);
		drain();
		cfg_ch.vector_count <= n;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_count = n;
		settings++;
	endtask

	task automatic random_items(int count);
		int unsigned      cap;
		int               pick;
		bit               live;
		action_t          act;
		logic [ID_W-1:0]  vid;
		logic [IDX_W-1:0] idx;
		live = cur_count != 0 && cur_count <= MAX_VECTORS;
		cap = live ? STORE_DEPTH / cur_count : 0;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				act = ACT_PUSH;
			else if (pick < 55)
				act = ACT_READ;
			else if (pick < 75)
				act = ACT_WRITE;
			else if (pick < 82)
				act = ACT_CLEAR_ONE;
			else if (pick < 85)
				act = ACT_CLEAR_ALL;
			else if (pick < 91)
				act = action_t'($urandom_range(int'(ACT_CLEAR_ALL) + 1, (1 << ACT_W) - 1));
			else
				act = action_t'($urandom);
			if (live && $urandom_range(0, 9) != 0)
				vid = ID_W'($urandom_range(0, cur_count - 1));
			else
				vid = ID_W'($urandom);
			pick = $urandom_range(0, 99);
			if (!live || pick < 25)
				idx = IDX_W'($urandom);
			else if (pick < 45)
				idx = IDX_W'($urandom_range(0, 7));
			else if (pick < 60)
				idx = IDX_W'(cap - $urandom_range(0, 2));
			else
				idx = IDX_W'($urandom_range(0, cap - 1));
			send_beat(act, vid, idx, BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_PUSH;
		req_ch.vector_id <= '0;
		req_ch.index <= '0;
		req_ch.value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.vector_count <= '0;
		phase_counts = '{5'd1, 5'd16, 5'd31, 5'd3, 5'd15, 5'd0, 5'd7, 5'd2, 5'd13, 5'd16, 5'd4};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset
		send_beat(ACT_PUSH, 4'd0, 12'd0, 8'hFF);
		send_beat(ACT_READ, 4'd0, 12'd0, 8'h00);
		send_beat(ACT_CLEAR_ALL, 4'd0, 12'd0, 8'h00);

		// one segment spanning the whole store
		set_vector_count(5'd1);
		send_beat(ACT_PUSH, 4'd0, 12'd0, 8'hFF);
		send_beat(ACT_PUSH, 4'd0, 12'd0, 8'h00);
		send_beat(ACT_READ, 4'd0, 12'd0, 8'h00);
		send_beat(ACT_READ, 4'd0, 12'd4095, 8'h00);
		send_beat(ACT_WRITE, 4'd0, 12'd4095, 8'hA5);
		send_beat(ACT_PUSH, 4'd0, 12'd0, 8'h3C);
		send_beat(ACT_READ, 4'd0, 12'd4095, 8'h00);
		send_beat(ACT_WRITE, 4'd0, 12'd1, 8'h5A);
		send_beat(ACT_CLEAR_ONE, 4'd0, 12'd0, 8'h00);
		send_beat(ACT_READ, 4'd0, 12'd4095, 8'h00);
		send_beat(ACT_PUSH, 4'd1, 12'd0, 8'h11);
		send_beat(ACT_WRITE, 4'd15, 12'd0, 8'h22);
		for (int a = int'(ACT_CLEAR_ALL) + 1; a < (1 << ACT_W); a++)
			send_beat(action_t'(a), 4'd0, 12'd0, 8'h00);
		send_beat(ACT_CLEAR_ALL, 4'd9, 12'd0, 8'h00);

		// sixteen segments of 256
		set_vector_count(5'd16);
		send_beat(ACT_READ, 4'd15, 12'd256, 8'h00);
		send_beat(ACT_WRITE, 4'd15, 12'd255, 8'hFF);
		send_beat(ACT_READ, 4'd15, 12'd255, 8'h00);
		send_beat(ACT_WRITE, 4'd0, 12'd4095, 8'h77);

		for (int p = 0; p < PHASES; p++) begin
			quiet = (p % 3 == 0);
			set_vector_count(phase_counts[p]);
			if (p == 3)
				want_hold = 1'b1;
			random_items((phase_counts[p] == 0 || phase_counts[p] > MAX_VECTORS) ? 40 : 195);
		end
		quiet = 1'b0;
		drain();

		$display("covered %0d request beats over %0d vector count settings (disabled, 1 to 16, 31),",
			requests, settings);
		$display("%0d responses checked, response path held off once for %0d cycles",
			checked, HOLD_CYCLES);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: partitioned_byte_vector_store.f
sv/pbvs_pkg.sv
sv/pbvs_if.sv
sv/pbvs_byte_ram.sv
sv/pbvs_ctrl.sv
sv/partitioned_byte_vector_store.sv
sim/pbvs_store_checker.sv
sim/partitioned_byte_vector_store_tb.sv
